[design/tsni_pkg.sv]
// Shared types and constants for the TLS record scanner and server name extractor.
`default_nettype none
package tsni_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       want_name;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  name_char;
        logic        name_end;
        logic [31:0] record_bytes;
        logic        saw_client_hello;
        logic        saw_server_hello;
    } t_out_item;

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_NO_NAME = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [7:0] TYPE_MIN       = 8'd20;
    localparam logic [7:0] TYPE_MAX       = 8'd23;
    localparam logic [7:0] TYPE_HANDSHAKE = 8'd22;
    localparam logic [15:0] HELLO_FIXED_SKIP = 16'd37;
    localparam logic [15:0] NAME_PRE_SKIP    = 16'd5;
    localparam logic [16:0] POS_MAX          = 17'h1FFFF;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_HEAD    = 4'd1;
    localparam logic [3:0] PH_SID     = 4'd2;
    localparam logic [3:0] PH_CIPH_LO = 4'd3;
    localparam logic [3:0] PH_CIPH    = 4'd4;
    localparam logic [3:0] PH_EXT     = 4'd5;
    localparam logic [3:0] PH_TYPE_LO = 4'd6;
    localparam logic [3:0] PH_ELEN_HI = 4'd7;
    localparam logic [3:0] PH_ELEN_LO = 4'd8;
    localparam logic [3:0] PH_PRE     = 4'd9;
    localparam logic [3:0] PH_NLEN_LO = 4'd10;
    localparam logic [3:0] PH_NAME    = 4'd11;

    // Results of one request, as they go from the scanner to the output queue.
    typedef struct packed {
        logic      walk_vld;
        t_out_item walk_res;
        logic      sum_vld;
        t_out_item sum_res;
    } t_pair;
endpackage
`default_nettype wire

[design/tls_record_scan_sni_extract.sv]
// Top level of the TLS record scanner and server name extractor.
// Usage:
//   Input channel: payload bytes as requests; a request is taken when i_push is
//   high and o_full is low. first_byte restarts the scan, want_name is sampled
//   there, last_byte closes the payload and yields a summary.
//   Result channel: queue style; the oldest result shows while o_empty is low
//   and is taken when i_pop is high.
//   Each request gives zero to two results: a name byte or "no name" from the
//   ClientHello walk, then the summary on the last byte.
// Results are written into the result queue in the same cycle that their request is taken.
// Throughput: one request per cycle while o_full is low; the scanner updates its state on each taken request.
//   o_full rises only while fewer than two result slots are free in the
//   DEPTH-entry result queue, so a stalled receiver backs up into the input.
// Reset: synchronous, clears the scan state and empties the queue.
`default_nettype none
module tls_record_scan_sni_extract #(
    parameter int DEPTH = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire tsni_pkg::t_in_item i_in,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output tsni_pkg::t_out_item     o_out
);
    import tsni_pkg::*;

    t_pair pair;
    logic  room;
    logic  acc;

    assign o_full = !room;
    assign acc    = i_push && room;

    tsni_scan u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(acc), .i_item(i_in), .o_pair(pair)
    );

    tsni_outq #(.DEPTH(DEPTH)) u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(acc), .i_pair(pair), .o_room(room),
        .o_empty(o_empty), .i_pop(i_pop), .o_item(o_out)
    );
endmodule
`default_nettype wire

[design/tsni_scan.sv]
// Front part: header window scan, handshake type check and server name walk.
`default_nettype none
module tsni_scan (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire tsni_pkg::t_in_item i_item,
    output tsni_pkg::t_pair        o_pair
);
    import tsni_pkg::*;

    logic [31:0] r_win, n_win;
    logic [2:0]  r_fill, n_fill;
    logic [16:0] r_blk, n_blk;
    logic        r_await, n_await;
    logic        r_is_hs, n_is_hs;
    logic [3:0]  r_ph, n_ph;
    logic [15:0] r_cnt, n_cnt;
    logic [16:0] r_pos, n_pos;
    logic [15:0] r_lim, n_lim;
    logic [15:0] r_latch, n_latch;
    logic [31:0] r_sum, n_sum;
    logic [2:0]  r_flags, n_flags;

    logic [7:0]  b;
    logic [15:0] v;
    logic [15:0] len;
    logic [7:0]  t_b, maj, mnr;
    logic [32:0] sum_ext;
    logic [17:0] pos_chk;

    always_comb begin
        b = i_item.data_byte;
        n_win = r_win; n_fill = r_fill; n_blk = r_blk; n_await = r_await;
        n_is_hs = r_is_hs; n_ph = r_ph; n_cnt = r_cnt; n_pos = r_pos;
        n_lim = r_lim; n_latch = r_latch; n_sum = r_sum; n_flags = r_flags;
        o_pair = '0;
        v = '0; len = '0; sum_ext = '0; pos_chk = '0;
        t_b = r_win[31:24]; maj = r_win[23:16]; mnr = r_win[15:8];
        if (i_item.first_byte) begin
            n_win = '0; n_fill = '0; n_blk = '0; n_await = 1'b0; n_is_hs = 1'b0;
            n_ph = PH_IDLE; n_cnt = '0; n_pos = '0; n_lim = '0; n_latch = '0;
            n_sum = '0;
            n_flags = i_item.want_name ? 3'd4 : 3'd0;
            t_b = 8'd0; maj = 8'd0; mnr = 8'd0;
        end
        if (n_ph != PH_IDLE) begin
            if (n_pos != POS_MAX) n_pos = n_pos + 17'd1;
            unique case (n_ph) inside
                PH_HEAD, PH_SID, PH_CIPH, PH_EXT, PH_PRE: begin
                    if (n_cnt != 16'd0) begin
                        n_cnt = n_cnt - 16'd1;
                    end else if (n_ph == PH_HEAD) begin
                        n_cnt = {8'd0, b}; n_ph = PH_SID;
                    end else if (n_ph == PH_CIPH) begin
                        n_cnt = {8'd0, b} + 16'd2; n_ph = PH_EXT;
                    end else begin
                        n_latch = {b, 8'd0};
                        n_ph = (n_ph == PH_SID) ? PH_CIPH_LO :
                               (n_ph == PH_EXT) ? PH_TYPE_LO : PH_NLEN_LO;
                    end
                end
                PH_CIPH_LO: begin
                    n_cnt = n_latch | {8'd0, b}; n_ph = PH_CIPH;
                end
                PH_TYPE_LO: begin
                    v = n_latch | {8'd0, b};
                    if (v != 16'd0) n_ph = PH_ELEN_HI;
                    else begin
                        n_cnt = NAME_PRE_SKIP; n_ph = PH_PRE;
                    end
                end
                PH_ELEN_HI: begin
                    n_latch = {b, 8'd0}; n_ph = PH_ELEN_LO;
                end
                PH_ELEN_LO: begin
                    v = n_latch | {8'd0, b};
                    pos_chk = {1'b0, n_pos} + {2'b0, v} + 18'd6;
                    if (pos_chk >= {2'b0, n_lim}) begin
                        n_ph = PH_IDLE;
                        o_pair.walk_vld = 1'b1;
                        o_pair.walk_res.result_kind = KIND_NO_NAME;
                    end else begin
                        n_cnt = v; n_ph = PH_EXT;
                    end
                end
                PH_NLEN_LO: begin
                    v = n_latch | {8'd0, b};
                    if (v == 16'd0) begin
                        n_ph = PH_IDLE;
                        o_pair.walk_vld = 1'b1;
                        o_pair.walk_res.result_kind = KIND_NO_NAME;
                    end else begin
                        n_cnt = v; n_ph = PH_NAME;
                    end
                end
                PH_NAME: begin
                    o_pair.walk_vld = 1'b1;
                    o_pair.walk_res.result_kind = KIND_NAME;
                    o_pair.walk_res.name_char = b;
                    o_pair.walk_res.name_end = (n_cnt == 16'd1);
                    if (n_cnt != 16'd0) n_cnt = n_cnt - 16'd1;
                    if (n_cnt == 16'd0) n_ph = PH_IDLE;
                end
                default: n_ph = PH_IDLE;
            endcase
        end
        if (n_await) begin
            n_await = 1'b0;
            if (n_is_hs) begin
                if (b == 8'd1) begin
                    n_flags[0] = 1'b1;
                    if (n_flags[2]) begin
                        n_flags[2] = 1'b0;
                        n_ph = PH_HEAD; n_cnt = HELLO_FIXED_SKIP; n_pos = '0;
                    end
                end else if (b == 8'd2) begin
                    n_flags[1] = 1'b1;
                end
            end
            n_is_hs = 1'b0;
        end
        if (n_fill >= 3'd4) begin
            if (n_blk != 17'd0) begin
                n_blk = n_blk - 17'd1;
            end else if (t_b >= TYPE_MIN && t_b <= TYPE_MAX && maj == 8'd3 &&
                         mnr >= 8'd1 && mnr <= 8'd4) begin
                len = {n_win[7:0], b};
                sum_ext = {1'b0, n_sum} + {17'd0, len};
                n_sum = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
                n_blk = {1'b0, len} + 17'd4;
                n_await = 1'b1;
                n_is_hs = (t_b == TYPE_HANDSHAKE);
                if (n_flags[2]) n_lim = len;
            end
        end
        n_win = {n_win[23:0], b};
        if (n_fill < 3'd4) n_fill = n_fill + 3'd1;
        if (i_item.last_byte) begin
            o_pair.sum_vld = 1'b1;
            o_pair.sum_res.result_kind = KIND_SUMMARY;
            o_pair.sum_res.record_bytes = n_sum;
            o_pair.sum_res.saw_client_hello = n_flags[0];
            o_pair.sum_res.saw_server_hello = n_flags[1];
            n_win = '0; n_fill = '0; n_blk = '0; n_await = 1'b0; n_is_hs = 1'b0;
            n_ph = PH_IDLE; n_cnt = '0; n_pos = '0; n_lim = '0; n_latch = '0;
            n_sum = '0; n_flags = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0; r_fill <= '0; r_blk <= '0; r_await <= 1'b0; r_is_hs <= 1'b0;
            r_ph <= PH_IDLE; r_cnt <= '0; r_pos <= '0; r_lim <= '0; r_latch <= '0;
            r_sum <= '0; r_flags <= '0;
        end else if (i_en) begin
            r_win <= n_win; r_fill <= n_fill; r_blk <= n_blk; r_await <= n_await;
            r_is_hs <= n_is_hs; r_ph <= n_ph; r_cnt <= n_cnt; r_pos <= n_pos;
            r_lim <= n_lim; r_latch <= n_latch; r_sum <= n_sum; r_flags <= n_flags;
        end
    end
endmodule
`default_nettype wire

[design/tsni_outq.sv]
// Back part: result queue that takes up to two results per request.
`default_nettype none
module tsni_outq #(
    parameter int DEPTH = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr,
    input  wire tsni_pkg::t_pair    i_pair,
    output logic                    o_room,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output tsni_pkg::t_out_item     o_item
);
    import tsni_pkg::*;
    localparam int AW = $clog2(DEPTH);

    t_out_item           r_mem [DEPTH];
    logic [AW-1:0]       r_wp, r_rp;
    logic [AW:0]         r_cnt, n_cnt;
    logic                do_pop;
    logic [1:0]          nwr;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign o_room  = ({1'b0, r_cnt} + (AW+2)'(2)) <= (AW+2)'(DEPTH);
    assign nwr     = i_wr ? (2'({1'b0, i_pair.walk_vld}) + 2'({1'b0, i_pair.sum_vld})) : 2'd0;
    assign n_cnt   = r_cnt + (AW+1)'(nwr) - (AW+1)'(do_pop);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            if (i_pair.walk_vld) begin
                r_mem[r_wp] <= i_pair.walk_res;
                if (i_pair.sum_vld) r_mem[r_wp + AW'(1)] <= i_pair.sum_res;
            end else if (i_pair.sum_vld) begin
                r_mem[r_wp] <= i_pair.sum_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(nwr);
            r_rp  <= r_rp + AW'(do_pop);
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

[design/tsni_chk.sv]
// Port checker for the top level, with its bind.
`default_nettype none
module tsni_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_push,
    input wire logic               o_full,
    input wire tsni_pkg::t_in_item i_in,
    input wire logic               o_empty,
    input wire logic               i_pop,
    input wire tsni_pkg::t_out_item o_out
);
    import tsni_pkg::*;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("queue not empty after reset");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> $stable(o_out))
        else $error("result changed while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_out.result_kind != 2'd3)
        else $error("bad result kind");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !o_full && i_in.last_byte |=> !o_empty)
        else $error("no summary after last byte");
endmodule
bind tls_record_scan_sni_extract tsni_chk u_chk (.*);
`default_nettype wire

[dv/tls_record_scan_sni_extract_checker.sv]
// Checker: predicts scanner results from accepted requests and compares them with the output.
`default_nettype none
module tls_record_scan_sni_extract_checker
    import tsni_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire logic      i_full,
    input  wire t_in_item  i_in,
    input  wire logic      i_empty,
    input  wire logic      i_pop,
    input  wire t_out_item i_out,
    output int             o_errors,
    output int             o_pending
);
    t_out_item   exp_q[$];
    logic [31:0] win;
    logic [2:0]  fill;
    logic [16:0] skip_cnt;
    logic        hs_pending;
    logic        rec_hs;
    logic [3:0]  phase;
    logic [15:0] fcount;
    logic [16:0] hpos;
    logic [15:0] hlimit;
    logic [15:0] hi_latch;
    logic [31:0] total;
    logic [2:0]  flags;

    function automatic t_out_item mk(logic [1:0] k, logic [7:0] ch, logic e,
                                     logic [31:0] t, logic c, logic s);
        t_out_item r;
        r.result_kind = k;
        r.name_char = ch;
        r.name_end = e;
        r.record_bytes = t;
        r.saw_client_hello = c;
        r.saw_server_hello = s;
        return r;
    endfunction

    task automatic clear_state();
        win = '0; fill = '0; skip_cnt = '0; hs_pending = 0; rec_hs = 0;
        phase = PH_IDLE; fcount = '0; hpos = '0; hlimit = '0; hi_latch = '0;
        total = '0; flags = '0;
    endtask

    task automatic walk(logic [7:0] b);
        logic [15:0] v;
        v = {hi_latch[15:8], b};
        if (hpos < POS_MAX) hpos = hpos + 1;
        case (phase) inside
            PH_HEAD, PH_SID, PH_CIPH, PH_EXT, PH_PRE: begin
                if (fcount > 0) begin
                    fcount = fcount - 1;
                end else if (phase == PH_HEAD) begin
                    fcount = {8'd0, b}; phase = PH_SID;
                end else if (phase == PH_CIPH) begin
                    fcount = {8'd0, b} + 16'd2; phase = PH_EXT;
                end else begin
                    hi_latch = {b, 8'd0};
                    phase = (phase == PH_SID) ? PH_CIPH_LO :
                            (phase == PH_EXT) ? PH_TYPE_LO : PH_NLEN_LO;
                end
            end
            PH_CIPH_LO: begin
                fcount = v; phase = PH_CIPH;
            end
            PH_TYPE_LO: begin
                if (v != 0) phase = PH_ELEN_HI;
                else begin
                    fcount = NAME_PRE_SKIP; phase = PH_PRE;
                end
            end
            PH_ELEN_HI: begin
                hi_latch = {b, 8'd0}; phase = PH_ELEN_LO;
            end
            PH_ELEN_LO: begin
                if (32'(hpos) + 32'(v) + 32'd6 >= 32'(hlimit)) begin
                    phase = PH_IDLE;
                    exp_q.push_back(mk(KIND_NO_NAME, 0, 0, 0, 0, 0));
                end else begin
                    fcount = v; phase = PH_EXT;
                end
            end
            PH_NLEN_LO: begin
                if (v == 0) begin
                    phase = PH_IDLE;
                    exp_q.push_back(mk(KIND_NO_NAME, 0, 0, 0, 0, 0));
                end else begin
                    fcount = v; phase = PH_NAME;
                end
            end
            PH_NAME: begin
                exp_q.push_back(mk(KIND_NAME, b, fcount == 1, 0, 0, 0));
                if (fcount > 0) fcount = fcount - 1;
                if (fcount == 0) phase = PH_IDLE;
            end
            default: phase = PH_IDLE;
        endcase
    endtask

    task automatic predict(t_in_item it);
        logic [7:0]  b;
        logic [15:0] len;
        b = it.data_byte;
        if (it.first_byte) begin
            clear_state();
            if (it.want_name) flags = 3'b100;
        end
        if (phase != PH_IDLE) walk(b);
        if (hs_pending) begin
            hs_pending = 0;
            if (rec_hs) begin
                if (b == 8'd1) begin
                    flags[0] = 1;
                    if (flags[2]) begin
                        flags[2] = 0;
                        phase = PH_HEAD;
                        fcount = HELLO_FIXED_SKIP;
                        hpos = '0;
                    end
                end else if (b == 8'd2) begin
                    flags[1] = 1;
                end
            end
            rec_hs = 0;
        end
        if (fill >= 3'd4) begin
            if (skip_cnt > 0) begin
                skip_cnt = skip_cnt - 1;
            end else if (win[31:24] >= TYPE_MIN && win[31:24] <= TYPE_MAX &&
                         win[23:16] == 8'd3 && win[15:8] >= 8'd1 && win[15:8] <= 8'd4) begin
                len = {win[7:0], b};
                total = (total > 32'hFFFF_FFFF - 32'(len)) ? 32'hFFFF_FFFF
                                                           : total + 32'(len);
                skip_cnt = 17'd4 + 17'(len);
                hs_pending = 1;
                rec_hs = (win[31:24] == TYPE_HANDSHAKE);
                if (flags[2]) hlimit = len;
            end
        end
        win = {win[23:0], b};
        if (fill < 3'd4) fill = fill + 1;
        if (it.last_byte) begin
            exp_q.push_back(mk(KIND_SUMMARY, 0, 0, total, flags[0], flags[1]));
            clear_state();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            clear_state();
            exp_q.delete();
            o_errors <= 0;
        end else begin
            if (i_push && !i_full) predict(i_in);
            if (i_pop && !i_empty) begin
                if (exp_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", i_out);
                    o_errors <= o_errors + 1;
                end else begin
                    e = exp_q.pop_front();
                    if (i_out.result_kind !== e.result_kind || i_out.name_char !== e.name_char ||
                        i_out.name_end !== e.name_end || i_out.record_bytes !== e.record_bytes ||
                        i_out.saw_client_hello !== e.saw_client_hello ||
                        i_out.saw_server_hello !== e.saw_server_hello) begin
                        if (o_errors < 10) $display("mismatch: expected %p actual %p", e, i_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= exp_q.size();
    end
endmodule
`default_nettype wire

[dv/tls_record_scan_sni_extract_tb.sv]
// Testbench top: drives payload bytes and result pops, and reports the verdict.
`default_nettype none
module tls_record_scan_sni_extract_tb;
    import tsni_pkg::*;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_push = 0;
    logic      i_pop = 0;
    t_in_item  i_in = '0;
    logic      o_full, o_empty;
    t_out_item o_out;
    int        errs, pend;
    int        cyc = 0;
    int        hold = 0;
    int        stall_cnt = 0;
    logic      full_s = 1;
    t_in_item  pay_q[$];
    int        sent = 0;

    always #2 i_clk = ~i_clk;

    tls_record_scan_sni_extract dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full), .i_in(i_in),
        .o_empty(o_empty), .i_pop(i_pop), .o_out(o_out)
    );

    tls_record_scan_sni_extract_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_full(o_full), .i_in(i_in),
        .i_empty(o_empty), .i_pop(i_pop), .i_out(o_out), .o_errors(errs), .o_pending(pend)
    );

    function automatic logic quiet();
        return cyc >= 600 && cyc < 1200;
    endfunction

    always @(posedge i_clk) cyc <= cyc + 1;
    always @(negedge i_clk) full_s = o_full;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 0;
        end else if (hold > 0) begin
            hold <= hold - 1;
            i_pop <= 0;
        end else if (cyc == 1500) begin
            hold <= 300;
            i_pop <= 0;
        end else begin
            i_pop <= quiet() || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                stall_cnt <= 0;
            end else begin
                stall_cnt <= stall_cnt + 1;
                if (stall_cnt == 2000) begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    task automatic add(logic [7:0] b);
        t_in_item it;
        it.data_byte = b;
        it.first_byte = ($urandom_range(0, 99) < 2);
        it.last_byte = ($urandom_range(0, 99) < 2);
        it.want_name = $urandom_range(0, 1);
        pay_q.push_back(it);
    endtask

    task automatic add16(int v);
        add(v[15:8]);
        add(v[7:0]);
    endtask

    task automatic add_rand(int n);
        repeat (n) add($urandom_range(0, 255));
    endtask

    // Marks and sends the queued payload.
    task automatic flush(logic mark_first, logic mark_last, logic want);
        if (pay_q.size() > 0) begin
            if (mark_first) begin
                pay_q[0].first_byte = 1;
                pay_q[0].want_name = want;
            end
            if (mark_last) pay_q[pay_q.size() - 1].last_byte = 1;
        end
        while (pay_q.size() > 0) begin
            if (!quiet() && $urandom_range(0, 99) < 20) begin
                i_push <= 0;
                @(posedge i_clk);
            end
            i_push <= 1;
            i_in <= pay_q.pop_front();
            sent++;
            do @(posedge i_clk); while (full_s);
        end
    endtask

    task automatic gen_hello();
        t_in_item body[$];
        int n, rlen, sidl, cl, ml, k, el;
        t_in_item hdr[$];
        pay_q.delete();
        add(1);
        add(0); add16($urandom_range(0, 400));
        add(3); add($urandom_range(1, 4));
        add_rand(32);
        sidl = $urandom_range(0, 4);
        add(sidl); add_rand(sidl);
        cl = 2 * $urandom_range(1, 3);
        add16(cl); add_rand(cl);
        ml = $urandom_range(1, 2);
        add(ml); add_rand(ml);
        add16($urandom_range(0, 100));
        k = $urandom_range(0, 2);
        repeat (k) begin
            add16($urandom_range(1, 65535));
            el = $urandom_range(0, 4);
            add16(el); add_rand(el);
        end
        if ($urandom_range(0, 99) < 80) begin
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            add16(0); add16(n + 5); add16(n + 3); add(0);
            add16(n); add_rand(n);
        end
        if ($urandom_range(0, 1)) begin
            add16($urandom_range(1, 65535)); add16(2); add_rand(2);
        end
        body = pay_q;
        pay_q.delete();
        case ($urandom_range(0, 9))
            0: rlen = $urandom_range(0, 5);
            1: rlen = $urandom_range(0, 65535);
            default: rlen = body.size();
        endcase
        if ($urandom_range(0, 3) == 0) add_rand($urandom_range(1, 6));
        add(TYPE_HANDSHAKE); add(3); add($urandom_range(1, 4)); add16(rlen);
        hdr = pay_q;
        pay_q = {hdr, body};
        if ($urandom_range(0, 3) == 0) begin
            add(TYPE_HANDSHAKE); add(3); add(3); add16(4); add(2); add_rand(3);
        end
        if ($urandom_range(0, 9) == 0) pay_q = pay_q[0:$urandom_range(0, pay_q.size() - 1)];
        flush($urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0,
              $urandom_range(0, 9) != 0);
    endtask

    task automatic noise();
        int n;
        pay_q.delete();
        n = $urandom_range(3, 30);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                add($urandom_range(18, 25)); add(3); add($urandom_range(0, 5));
                add16($urandom_range(0, 8));
                add($urandom_range(0, 3));
            end else begin
                add_rand(1);
            end
        end
        flush($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, $urandom_range(0, 1));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        // before any first byte, then header extremes
        pay_q.delete();
        add(23); add(3); add(4); add(8'hFF); add(8'hFF);
        flush(0, 1, 0);
        add(20); add(3); add(1); add(0); add(0); add(22);
        flush(1, 1, 1);
        add(19); add(3); add(1); add(0); add(1); add(24); add(3); add(5); add(0); add(0);
        flush(1, 1, 0);
        add(22); add(3); add(0); add(0); add(4); add(2); add(0);
        flush(1, 1, 1);
        add(8'h00); add(8'hFF);
        flush(0, 0, 0);
        while (sent < 1650) begin
            if ($urandom_range(0, 99) < 70) gen_hello();
            else noise();
        end
        i_push <= 0;
        @(posedge i_clk);
        while (pend != 0 || !o_empty) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errs == 0 && pend == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
